// ===== sv/ftga_pkg.sv =====
// Shared types and constants for the two-resource grant arbiter.
`timescale 1ns / 1ps

package ftga_pkg;

    localparam int ID_W      = 3;   // client id width
    localparam int SEAT_W    = 4;   // seat count register width
    localparam int RES_CNT_W = 3;   // results per request counter width

    localparam logic [SEAT_W-1:0]    SEAT_RESET   = 4'd5;
    localparam logic [RES_CNT_W-1:0] RESULT_LIMIT = 3'd4;

    typedef enum logic
    {
        FUNC_ACQUIRE = 1'b0,
        FUNC_RELEASE = 1'b1
    } ftga_func_t;

    typedef enum logic
    {
        STATUS_GRANT = 1'b0,
        STATUS_DROP  = 1'b1
    } ftga_status_t;

    // controller -> datapath
    typedef struct packed
    {
        logic latch_in;   // capture request, clear result count
        logic apply;      // enqueue / release / drop
        logic pop;        // discard a stale head entry
        logic grant;      // grant the head, load it as pending result
        logic push_pend;  // move the pending result to the output register
        logic push_last;  // pending result is the final one
    } ftga_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic queue_empty;
        logic limit_hit;
        logic head_stale;
        logic head_blocked;
        logic pend_valid;
        logic out_free;
    } ftga_stat_t;

endpackage

// ===== sv/ftga_ifs.sv =====
// Channel interfaces: request input, result output and seat count write.
`timescale 1ns / 1ps

interface ftga_req_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [ftga_pkg::ID_W-1:0] client_id;

    modport source (output valid, output func, output client_id, input ready);
    modport sink   (input valid, input func, input client_id, output ready);
endinterface

interface ftga_res_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [ftga_pkg::ID_W-1:0] granted_client;
    logic                      last;

    modport source (output valid, output status, output granted_client, output last,
                    input ready);
    modport sink   (input valid, input status, input granted_client, input last,
                    output ready);
endinterface

interface ftga_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ftga_pkg::SEAT_W-1:0] seat_count;

    modport source (output valid, output seat_count, input ready);
    modport sink   (input valid, input seat_count, output ready);
endinterface

// ===== sv/ftga_ctrl.sv =====
// Sequencing state machine of the two-resource grant arbiter.
`timescale 1ns / 1ps

module ftga_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ftga_pkg::ftga_stat_t stat,
    output ftga_pkg::ftga_cmd_t  cmd
);
    import ftga_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_APPLY,
        S_READ,
        S_CHECK,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                // head entry is being fetched from the queue memory
                if (stat.queue_empty || stat.limit_hit)
                    state_next = S_FLUSH;
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.head_stale)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_READ;
                end
                else if (stat.head_blocked)
                begin
                    state_next = S_FLUSH;
                end
                else if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.grant     = 1'b1;
                    cmd.push_pend = stat.pend_valid;
                    state_next    = S_READ;
                end
            end
            S_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.push_pend = 1'b1;
                    cmd.push_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ===== sv/ftga_dp.sv =====
// Datapath: seat register, busy marks, wait queue, pending and output registers.
`timescale 1ns / 1ps

module ftga_dp
#(
    parameter int MAX_SEATS   = 8,
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ftga_pkg::SEAT_W-1:0] cfg_data,
    input  logic                        in_func,
    input  logic [ftga_pkg::ID_W-1:0]   in_client_id,
    input  ftga_pkg::ftga_cmd_t         cmd,
    output ftga_pkg::ftga_stat_t        stat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_status,
    output logic [ftga_pkg::ID_W-1:0]   out_client,
    output logic                        out_last
);
    import ftga_pkg::*;

    localparam int SW = ($clog2(MAX_SEATS + 1) > SEAT_W) ? $clog2(MAX_SEATS + 1) : SEAT_W;
    localparam int BW = $clog2(MAX_SEATS);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [SW-1:0] partner(input logic [SW-1:0] x,
                                              input logic [SW-1:0] n);
        logic [SW-1:0] inc;
        inc = x + SW'(1);
        return (inc == n) ? '0 : inc;
    endfunction

    function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] p);
        return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
    endfunction

    logic [SEAT_W-1:0]    seat_count_reg;
    logic [MAX_SEATS-1:0] busy_reg;
    logic [MAX_SEATS-1:0] busy_next;
    logic [ID_W-1:0]      queue_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]      rd_data_reg;
    logic [QW-1:0]        head_reg;
    logic [QW-1:0]        tail_reg;
    logic [CW-1:0]        cnt_reg;
    logic [RES_CNT_W-1:0] res_cnt_reg;
    ftga_func_t           func_reg;
    logic [ID_W-1:0]      id_reg;
    logic                 pend_valid_reg;
    ftga_status_t         pend_status_reg;
    logic [ID_W-1:0]      pend_client_reg;
    logic                 out_valid_reg;
    logic                 out_status_reg;
    logic [ID_W-1:0]      out_client_reg;
    logic                 out_last_reg;

    logic [SW-1:0] seats;
    logic [SW-1:0] sc_ext;
    logic [SW-1:0] id_ext;
    logic [SW-1:0] id_other;
    logic [SW-1:0] head_ext;
    logic [SW-1:0] head_other;
    logic          id_ok;
    logic          full;
    logic          enq;
    logic          drop;
    logic          rel;
    logic          pop;
    logic          out_free;

    // clamp the seat count into 2..MAX_SEATS
    always_comb
    begin
        sc_ext = SW'(seat_count_reg);
        if (sc_ext < SW'(2))
            seats = SW'(2);
        else if (sc_ext > SW'(MAX_SEATS))
            seats = SW'(MAX_SEATS);
        else
            seats = sc_ext;
    end

    assign id_ext     = SW'(id_reg);
    assign id_ok      = (id_ext < seats);
    assign id_other   = partner(id_ext, seats);
    assign head_ext   = SW'(rd_data_reg);
    assign head_other = partner(head_ext, seats);
    assign full       = (cnt_reg == CW'(QUEUE_DEPTH));
    assign enq        = cmd.apply && id_ok && (func_reg == FUNC_ACQUIRE) && !full;
    assign drop       = cmd.apply && id_ok && (func_reg == FUNC_ACQUIRE) && full;
    assign rel        = cmd.apply && id_ok && (func_reg == FUNC_RELEASE);
    assign pop        = cmd.pop || cmd.grant;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        busy_next = busy_reg;
        if (rel)
        begin
            busy_next[id_ext[BW-1:0]]   = 1'b0;
            busy_next[id_other[BW-1:0]] = 1'b0;
        end
        if (cmd.grant)
        begin
            busy_next[head_ext[BW-1:0]]   = 1'b1;
            busy_next[head_other[BW-1:0]] = 1'b1;
        end
    end

    always_comb
    begin
        stat.queue_empty  = (cnt_reg == '0);
        stat.limit_hit    = (res_cnt_reg == RESULT_LIMIT);
        stat.head_stale   = (head_ext >= seats);
        stat.head_blocked = busy_reg[head_ext[BW-1:0]] || busy_reg[head_other[BW-1:0]];
        stat.pend_valid   = pend_valid_reg;
        stat.out_free     = out_free;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seat_count_reg <= SEAT_RESET;
            busy_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            cnt_reg        <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                seat_count_reg <= cfg_data;
            busy_reg <= busy_next;
            if (enq)
            begin
                tail_reg <= next_slot(tail_reg);
                cnt_reg  <= cnt_reg + CW'(1);
            end
            else if (pop)
            begin
                head_reg <= next_slot(head_reg);
                cnt_reg  <= cnt_reg - CW'(1);
            end
            if (cmd.latch_in)
                res_cnt_reg <= '0;
            else if (drop || cmd.grant)
                res_cnt_reg <= res_cnt_reg + RES_CNT_W'(1);
            if (drop || cmd.grant)
                pend_valid_reg <= 1'b1;
            else if (cmd.push_pend)
                pend_valid_reg <= 1'b0;
            if (cmd.push_pend)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (enq)
            queue_mem[tail_reg] <= id_reg;
        rd_data_reg <= queue_mem[head_reg];
        if (cmd.latch_in)
        begin
            func_reg <= ftga_func_t'(in_func);
            id_reg   <= in_client_id;
        end
        if (drop)
        begin
            pend_status_reg <= STATUS_DROP;
            pend_client_reg <= id_reg;
        end
        else if (cmd.grant)
        begin
            pend_status_reg <= STATUS_GRANT;
            pend_client_reg <= rd_data_reg;
        end
        if (cmd.push_pend)
        begin
            out_status_reg <= pend_status_reg;
            out_client_reg <= pend_client_reg;
            out_last_reg   <= cmd.push_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_client = out_client_reg;
    assign out_last   = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RESULT_LIMIT)
        else $error("result count above limit");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_pend |-> (out_free && pend_valid_reg))
        else $error("pending result pushed into a full output register");

    a_grant_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> (!pend_valid_reg || cmd.push_pend))
        else $error("grant would overwrite a pending result");

    a_grant_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> (cnt_reg != '0 && !stat.head_stale && !stat.head_blocked
                       && res_cnt_reg != RESULT_LIMIT))
        else $error("grant issued for an ineligible head");

endmodule

// ===== sv/fifo_two_resource_grant_arbiter.sv =====
// Top level of the FIFO-ordered two-resource grant arbiter.
`timescale 1ns / 1ps

// Channel | Dir | Payload                          | Handshake
// cfg     | in  | seat_count[3:0]                  | valid/ready, ready always high
// req     | in  | func, client_id[2:0]             | valid/ready
// res     | out | status, granted_client[2:0], last| valid/ready, output register
//
// A request goes from acceptance via apply, read, flush to ready; each entry granted
// or skipped as stale adds a check and a registered read, a blocked head a check.
// At most 4 grants or drops come out per request.
// Reset clears the busy marks and empties the queue at once; no clearing pass is needed.
// A held-off result output stalls the grant loop until the output register drains.
// Each result is buffered one step so its last flag is known when it leaves.

module fifo_two_resource_grant_arbiter
#(
    parameter int MAX_SEATS   = 8,
    parameter int QUEUE_DEPTH = 8
)
(
    input logic         clk,
    input logic         rst_n,
    ftga_cfg_if.sink    cfg,
    ftga_req_if.sink    req,
    ftga_res_if.source  res
);
    import ftga_pkg::*;

    ftga_cmd_t  cmd;
    ftga_stat_t stat;

    // seat count may be written at any time the block is idle
    assign cfg.ready = 1'b1;

    // sequence: capture request, apply it, then fetch and test the queue head
    ftga_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold busy marks, wait queue and the result registers
    ftga_dp
    #(
        .MAX_SEATS   (MAX_SEATS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid && cfg.ready),
        .cfg_data     (cfg.seat_count),
        .in_func      (req.func),
        .in_client_id (req.client_id),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (res.valid),
        .out_ready    (res.ready),
        .out_status   (res.status),
        .out_client   (res.granted_client),
        .out_last     (res.last)
    );

endmodule

// ===== bench/ftga_grant_checker.sv =====
// Checker for the grant arbiter: predicts grants and drops, compares every result.
`timescale 1ns / 1ps

module ftga_grant_checker
#(
    parameter int MAX_SEATS   = 8,
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic clk,
    input  logic rst_n,
    ftga_cfg_if  cfg,
    ftga_req_if  req,
    ftga_res_if  res,
    output int   mismatch_count,
    output int   grants_outstanding
);
    import ftga_pkg::*;

    typedef struct packed
    {
        ftga_status_t    status;
        logic [ID_W-1:0] client;
        logic            last;
    } grant_result_t;

    logic [SEAT_W-1:0] seat_reg;
    logic              resource_held [MAX_SEATS];
    logic [ID_W-1:0]   wait_slots [QUEUE_DEPTH];
    int                queue_head;
    int                queue_tail;
    int                queue_fill;
    grant_result_t     expected_grants [$];

    // Apply one request to the shadow state and queue up what it should produce.
    task automatic predict_request(input ftga_func_t op, input logic [ID_W-1:0] id);
        int            seats;
        int            who;
        int            mate;
        bit            blocked;
        grant_result_t burst [$];
        grant_result_t entry;
        seats = (seat_reg < 2) ? 2 : (seat_reg > MAX_SEATS) ? MAX_SEATS : int'(seat_reg);
        if (id < seats)
        begin
            if (op == FUNC_ACQUIRE)
            begin
                if (queue_fill >= QUEUE_DEPTH)
                begin
                    entry.status = STATUS_DROP;
                    entry.client = id;
                    entry.last   = 1'b0;
                    burst.push_back(entry);
                end
                else
                begin
                    wait_slots[queue_tail] = id;
                    queue_tail = (queue_tail + 1) % QUEUE_DEPTH;
                    queue_fill++;
                end
            end
            else
            begin
                resource_held[id] = 1'b0;
                resource_held[(id + 1) % seats] = 1'b0;
            end
        end
        // Grant the head while both its resources are free; drop stale heads silently.
        blocked = 1'b0;
        while (queue_fill > 0 && burst.size() < int'(RESULT_LIMIT) && !blocked)
        begin
            who  = wait_slots[queue_head];
            mate = (who + 1) % seats;
            if (who >= seats)
            begin
                queue_head = (queue_head + 1) % QUEUE_DEPTH;
                queue_fill--;
            end
            else if (resource_held[who] || resource_held[mate])
            begin
                blocked = 1'b1;
            end
            else
            begin
                resource_held[who]  = 1'b1;
                resource_held[mate] = 1'b1;
                queue_head = (queue_head + 1) % QUEUE_DEPTH;
                queue_fill--;
                entry.status = STATUS_GRANT;
                entry.client = ID_W'(who);
                entry.last   = 1'b0;
                burst.push_back(entry);
            end
        end
        if (burst.size() > 0)
        begin
            burst[burst.size() - 1].last = 1'b1;
        end
        foreach (burst[i])
        begin
            expected_grants.push_back(burst[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_result_t want;
        if (!rst_n)
        begin
            seat_reg   = SEAT_RESET;
            queue_head = 0;
            queue_tail = 0;
            queue_fill = 0;
            foreach (resource_held[i])
            begin
                resource_held[i] = 1'b0;
            end
            expected_grants.delete();
            mismatch_count = 0;
            grants_outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                seat_reg = cfg.seat_count;
            end
            if (req.valid && req.ready)
            begin
                predict_request(ftga_func_t'(req.func), req.client_id);
            end
            if (res.valid && res.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d client %0d last %0d",
                             $time, res.status, res.granted_client, res.last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (res.status !== want.status || res.granted_client !== want.client
                        || res.last !== want.last)
                    begin
                        $display("%0t: result mismatch, expected status %0d client %0d last %0d",
                                 $time, want.status, want.client, want.last,
                                 ", actual status %0d client %0d last %0d",
                                 res.status, res.granted_client, res.last);
                        mismatch_count++;
                    end
                end
            end
            grants_outstanding <= expected_grants.size();
        end
    end

endmodule

// ===== bench/tb_fifo_two_resource_grant_arbiter.sv =====
// Testbench top for the grant arbiter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_fifo_two_resource_grant_arbiter;

    import ftga_pkg::*;

    // Settle margin for the longest request, with every entry granted or skipped (8 queued)
    // and a blocked head ending the loop.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 14;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   mismatch_count;
    int   grants_outstanding;
    bit   sender_fast;
    bit   receiver_fast;

    ftga_cfg_if cfg ();
    ftga_req_if req ();
    ftga_res_if res ();

    fifo_two_resource_grant_arbiter u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .res   (res)
    );

    ftga_grant_checker u_checker
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .req                (req),
        .res                (res),
        .mismatch_count     (mismatch_count),
        .grants_outstanding (grants_outstanding)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs or stops producing results.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Hold each request for a random gap (none in fast stretches), then wait for acceptance.
    // Valid stays high across back-to-back requests so it is never dropped and raised in one step.
    task automatic push_request(input ftga_func_t op, input logic [ID_W-1:0] id);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.func      <= op;
        req.client_id <= id;
        do @(posedge clk); while (!req.ready);
    endtask

    // Write the seat count; only called while the block is idle.
    task automatic write_seats(input logic [SEAT_W-1:0] seats);
        cfg.valid      <= 1'b1;
        cfg.seat_count <= seats;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected result, then give the block time to finish
    // popping stale entries, which produce no result of their own.
    task automatic wait_until_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (grants_outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: stall a random number of cycles before taking each result.
    initial
    begin
        int stall;
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = receiver_fast ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!res.valid);
        end
    end

    initial
    begin
        logic [SEAT_W-1:0] seat_plan [9];
        logic [SEAT_W-1:0] seats;
        logic [ID_W-1:0]   id;
        ftga_func_t        op;
        int                ring;

        clk            = 1'b0;
        rst_n          = 1'b0;
        cycle_count    = 0;
        sender_fast    = 1'b0;
        receiver_fast  = 1'b0;
        cfg.valid      = 1'b0;
        cfg.seat_count = SEAT_RESET;
        req.valid      = 1'b0;
        req.func       = FUNC_ACQUIRE;
        req.client_id  = '0;

        // Reset once.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset ring of five.
        // Client 0 gets its pair at once; 1 waits on resource 1, and 2 queues behind it
        // even though its own pair is free, which shows the strict FIFO order.
        push_request(FUNC_ACQUIRE, 3'd0);
        push_request(FUNC_ACQUIRE, 3'd1);
        push_request(FUNC_ACQUIRE, 3'd2);
        // Releasing 0 unblocks 1 only; 2 still collides with 1 on resource 2.
        push_request(FUNC_RELEASE, 3'd0);
        // Client 4 wraps around the ring and needs resources 4 and 0.
        push_request(FUNC_ACQUIRE, 3'd4);
        // Out-of-range release is ignored.
        push_request(FUNC_RELEASE, 3'd6);
        // Releasing 1 lets 2 and 4 through in one burst.
        push_request(FUNC_RELEASE, 3'd1);
        push_request(FUNC_RELEASE, 3'd2);
        // Repeated release of the same client.
        push_request(FUNC_RELEASE, 3'd4);
        push_request(FUNC_RELEASE, 3'd4);
        wait_until_idle();

        // Full ring of eight: park 7, queue the even clients behind it, then release 7
        // so four grants come out of one request and hit the per-request limit.
        write_seats(4'd8);
        push_request(FUNC_ACQUIRE, 3'd7);
        push_request(FUNC_ACQUIRE, 3'd0);
        push_request(FUNC_ACQUIRE, 3'd2);
        push_request(FUNC_ACQUIRE, 3'd4);
        push_request(FUNC_ACQUIRE, 3'd6);
        push_request(FUNC_RELEASE, 3'd7);
        // Every resource is now held: fill the queue, duplicates included, then overflow it.
        push_request(FUNC_ACQUIRE, 3'd5);
        push_request(FUNC_ACQUIRE, 3'd7);
        push_request(FUNC_ACQUIRE, 3'd1);
        push_request(FUNC_ACQUIRE, 3'd3);
        push_request(FUNC_ACQUIRE, 3'd5);
        push_request(FUNC_ACQUIRE, 3'd7);
        push_request(FUNC_ACQUIRE, 3'd1);
        push_request(FUNC_ACQUIRE, 3'd3);
        push_request(FUNC_ACQUIRE, 3'd6);
        wait_until_idle();

        // Shrink the ring to four with 5 and 7 still queued: they become stale and
        // must be skipped without a result once the loop reaches them.
        write_seats(4'd4);
        push_request(FUNC_RELEASE, 3'd1);
        // Out-of-range acquire changes nothing, yet the loop still runs.
        push_request(FUNC_ACQUIRE, 3'd7);
        push_request(FUNC_RELEASE, 3'd3);
        wait_until_idle();

        // Random part: one phase per seat setting, extremes and clamped values included.
        seat_plan = '{4'd0, 4'd15, 4'd2, 4'd8, 4'd1, 4'd3, 4'd9, 4'd6, 4'd7};
        foreach (seat_plan[p])
        begin
            seats = seat_plan[p];
            ring  = (seats < 2) ? 2 : (seats > 8) ? 8 : int'(seats);
            write_seats(seats);
            // Rotate stretches with no idling on either side.
            sender_fast   = (p % 3 == 1);
            receiver_fast = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Mostly in-range clients so grants and queueing dominate; some strays.
                op = ($urandom_range(0, 99) < 55) ? FUNC_ACQUIRE : FUNC_RELEASE;
                if ($urandom_range(0, 7) == 0)
                begin
                    id = ID_W'($urandom_range(0, 7));
                end
                else
                begin
                    id = ID_W'($urandom_range(0, ring - 1));
                end
                push_request(op, id);
                // Hold off once mid-phase until every expected result is in.
                if (p == 2 && n == PHASE_ITEMS / 2)
                begin
                    wait_until_idle();
                end
            end
            wait_until_idle();
        end

        if (mismatch_count == 0 && grants_outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== fifo_two_resource_grant_arbiter.f =====
sv/ftga_pkg.sv
sv/ftga_ifs.sv
sv/ftga_ctrl.sv
sv/ftga_dp.sv
sv/fifo_two_resource_grant_arbiter.sv
bench/ftga_grant_checker.sv
bench/tb_fifo_two_resource_grant_arbiter.sv
